// ===== rtl/core/psbq_pkg.sv =====
// Shared constants and types for the point set byte quantizer.
package psbq_pkg;

    localparam int COORD_W    = 24;
    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int MC_W       = 7;
    localparam int MI_W       = 6;
    localparam int MC_MAX     = 64;
    localparam int MC_RESET   = 15;
    localparam int Q_W        = 8;
    localparam int QUANT_SCALE = 255;
    localparam int NUM_W      = COORD_W + Q_W;
    localparam int DSH_W      = COORD_W + Q_W - 1;
    localparam int STEP_W     = $clog2(Q_W);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        span_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_DRAIN  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    localparam logic RES_REPORT = 1'b0;
    localparam logic RES_BYTE   = 1'b1;

endpackage

// ===== rtl/core/point_set_byte_quantizer.sv =====
// Top level of the point set byte quantizer: point store, extents tracking and byte drain.
//
// Loads are taken one per cycle, and each writes one point into a 4096 x 72-bit
// synchronous point store; a finish passes its extents report through state S_DONE into
// the output register. Each drain transaction reads one stored point into the read register
// in state S_READ and then runs a restoring divider in S_DIV that produces one quotient bit
// per cycle; S_DIV is skipped when that axis has zero range. A new transaction is taken once
// the byte has been moved to the output register by S_DONE, so each drain tick waits for the
// byte of the previous one to get that far. The output register lets the next drain tick
// start while the previous byte still waits to be taken.
// The store needs no clearing after reset: only complete frames that were written are read.
module point_set_byte_quantizer
    import psbq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [MC_W-1:0]    cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [Q_W-1:0]     byte_value,
    output logic               last_byte,
    output logic signed [COORD_W-1:0] min_x,
    output logic signed [COORD_W-1:0] min_y,
    output logic signed [COORD_W-1:0] min_z,
    output logic [COORD_W-1:0] range_x,
    output logic [COORD_W-1:0] range_y,
    output logic [COORD_W-1:0] range_z
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_DONE
    } state_t;

    function automatic coord_t pick(input coord_t a0, input coord_t a1, input coord_t a2,
                                    input logic [1:0] sel);
        coord_t r;
        case (sel)
            2'd0:    r = a0;
            2'd1:    r = a1;
            default: r = a2;
        endcase
        return r;
    endfunction

    // point store
    logic [3*COORD_W-1:0] mem [MAX_POINTS];
    logic [3*COORD_W-1:0] rd_data_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [3*COORD_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;   // 1 while draining
    logic [MC_W-1:0]    mc_reg, mc_next;
    logic [MI_W-1:0]    mif_reg, mif_next;
    logic [CNT_W-1:0]   frames_reg, frames_next;
    logic [CNT_W-1:0]   fbase_reg, fbase_next;
    coord_t             lowest_reg [3];
    coord_t             lowest_next [3];
    coord_t             highest_reg [3];
    coord_t             highest_next [3];
    coord_t             flo_reg [3];
    coord_t             flo_next [3];
    coord_t             fhi_reg [3];
    coord_t             fhi_next [3];
    logic [MI_W-1:0]    dm_reg, dm_next;
    logic [1:0]         dax_reg, dax_next;
    logic [CNT_W-1:0]   df_reg, df_next;
    logic [ADDR_W-1:0]  daddr_reg, daddr_next;
    logic [1:0]         sel_ax_reg, sel_ax_next;
    coord_t             sel_lo_reg, sel_lo_next;
    span_t              sel_range_reg, sel_range_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [DSH_W-1:0]   dsh_reg, dsh_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               res_kind_reg, res_kind_next;
    logic               res_last_reg, res_last_next;
    coord_t             res_min_reg [3];
    coord_t             res_min_next [3];
    span_t              res_range_reg [3];
    span_t              res_range_next [3];
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [Q_W-1:0]     out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    coord_t             out_min_reg [3];
    coord_t             out_min_next [3];
    span_t              out_range_reg [3];
    span_t              out_range_next [3];

    coord_t             vin [3];
    coord_t             nflo [3];
    coord_t             nfhi [3];
    logic               accept;
    logic               frame_full;
    logic [MC_W-1:0]    mif_inc;
    logic               drain_last;
    coord_t             comp;
    span_t              off;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   dsh_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign vin[0] = coord_x;
    assign vin[1] = coord_y;
    assign vin[2] = coord_z;

    assign frame_full = ((CNT_W+1)'(fbase_reg) + (CNT_W+1)'(mc_reg)) > (CNT_W+1)'(MAX_POINTS);
    assign mif_inc    = MC_W'(mif_reg) + MC_W'(1);
    assign drain_last = (MC_W'(dm_reg) == mc_reg - MC_W'(1)) && (dax_reg == 2'd2)
                        && (df_reg == frames_reg - CNT_W'(1));

    assign mem_wdata = {coord_z, coord_y, coord_x};
    assign mem_waddr = ADDR_W'(fbase_reg + CNT_W'(mif_reg));
    assign mem_raddr = daddr_reg;

    assign comp    = pick(rd_data_reg[COORD_W-1:0], rd_data_reg[2*COORD_W-1:COORD_W],
                          rd_data_reg[3*COORD_W-1:2*COORD_W], sel_ax_reg);
    assign off     = span_t'(comp - sel_lo_reg);
    assign num     = {off, {Q_W{1'b0}}} - NUM_W'(off);
    assign dsh_ext = NUM_W'(dsh_reg);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        mc_next        = mc_reg;
        mif_next       = mif_reg;
        frames_next    = frames_reg;
        fbase_next     = fbase_reg;
        dm_next        = dm_reg;
        dax_next       = dax_reg;
        df_next        = df_reg;
        daddr_next     = daddr_reg;
        sel_ax_next    = sel_ax_reg;
        sel_lo_next    = sel_lo_reg;
        sel_range_next = sel_range_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        res_kind_next  = res_kind_reg;
        res_last_next  = res_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            lowest_next[a]    = lowest_reg[a];
            highest_next[a]   = highest_reg[a];
            flo_next[a]       = flo_reg[a];
            fhi_next[a]       = fhi_reg[a];
            res_min_next[a]   = res_min_reg[a];
            res_range_next[a] = res_range_reg[a];
            out_min_next[a]   = out_min_reg[a];
            out_range_next[a] = out_range_reg[a];
            nflo[a] = ((mif_reg == '0) || (vin[a] < flo_reg[a])) ? vin[a] : flo_reg[a];
            nfhi[a] = ((mif_reg == '0) || (vin[a] > fhi_reg[a])) ? vin[a] : fhi_reg[a];
        end

        if (cfg_we && !phase_reg && (frames_reg == '0) && (mif_reg == '0))
        begin
            if (cfg_wdata == '0)
            begin
                mc_next = MC_W'(1);
            end
            else if (cfg_wdata > MC_W'(MC_MAX))
            begin
                mc_next = MC_W'(MC_MAX);
            end
            else
            begin
                mc_next = cfg_wdata;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !phase_reg && (kind == KIND_LOAD))
                begin
                    if (!frame_full)
                    begin
                        mem_we = 1'b1;
                        for (int a = 0; a < 3; a++)
                        begin
                            flo_next[a] = nflo[a];
                            fhi_next[a] = nfhi[a];
                        end
                        if (mif_inc >= mc_reg)
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                if (nflo[a] < lowest_reg[a])
                                begin
                                    lowest_next[a] = nflo[a];
                                end
                                if (nfhi[a] > highest_reg[a])
                                begin
                                    highest_next[a] = nfhi[a];
                                end
                            end
                            mif_next    = '0;
                            frames_next = frames_reg + CNT_W'(1);
                            fbase_next  = fbase_reg + CNT_W'(mc_reg);
                        end
                        else
                        begin
                            mif_next = MI_W'(mif_inc);
                        end
                    end
                end
                else if (accept && !phase_reg && (kind == KIND_FINISH))
                begin
                    res_kind_next = RES_REPORT;
                    res_last_next = 1'b0;
                    q_next        = '0;
                    mif_next      = '0;
                    dm_next       = '0;
                    dax_next      = '0;
                    df_next       = '0;
                    daddr_next    = '0;
                    state_next    = S_DONE;
                    if (frames_reg == '0)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            res_min_next[a]   = '0;
                            res_range_next[a] = '0;
                            lowest_next[a]    = COORD_MAX;
                            highest_next[a]   = COORD_MIN;
                        end
                        frames_next = '0;
                        fbase_next  = '0;
                    end
                    else
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            res_min_next[a]   = lowest_reg[a];
                            res_range_next[a] = span_t'(highest_reg[a] - lowest_reg[a]);
                        end
                        phase_next = 1'b1;
                    end
                end
                else if (accept && phase_reg && (kind == KIND_DRAIN))
                begin
                    mem_re         = 1'b1;
                    sel_ax_next    = dax_reg;
                    sel_lo_next    = pick(lowest_reg[0], lowest_reg[1], lowest_reg[2], dax_reg);
                    sel_range_next = span_t'(pick(highest_reg[0], highest_reg[1],
                                                  highest_reg[2], dax_reg)
                                             - pick(lowest_reg[0], lowest_reg[1],
                                                    lowest_reg[2], dax_reg));
                    res_kind_next  = RES_BYTE;
                    res_last_next  = drain_last;
                    for (int a = 0; a < 3; a++)
                    begin
                        res_min_next[a]   = '0;
                        res_range_next[a] = '0;
                    end
                    state_next = S_READ;
                    if (drain_last)
                    begin
                        // end of stream: fresh session
                        for (int a = 0; a < 3; a++)
                        begin
                            lowest_next[a]  = COORD_MAX;
                            highest_next[a] = COORD_MIN;
                        end
                        phase_next  = 1'b0;
                        mif_next    = '0;
                        frames_next = '0;
                        fbase_next  = '0;
                        dm_next     = '0;
                        dax_next    = '0;
                        df_next     = '0;
                        daddr_next  = '0;
                    end
                    else if (df_reg != frames_reg - CNT_W'(1))
                    begin
                        df_next    = df_reg + CNT_W'(1);
                        daddr_next = ADDR_W'(CNT_W'(daddr_reg) + CNT_W'(mc_reg));
                    end
                    else if (dax_reg != 2'd2)
                    begin
                        df_next    = '0;
                        dax_next   = dax_reg + 2'd1;
                        daddr_next = ADDR_W'(dm_reg);
                    end
                    else
                    begin
                        df_next    = '0;
                        dax_next   = '0;
                        dm_next    = dm_reg + MI_W'(1);
                        daddr_next = ADDR_W'(dm_reg + MI_W'(1));
                    end
                end
            end

            S_READ:
            begin
                rem_next  = num;
                dsh_next  = {sel_range_reg, {(Q_W-1){1'b0}}};
                q_next    = '0;
                step_next = '0;
                state_next = (sel_range_reg == '0) ? S_DONE : S_DIV;
            end

            S_DIV:
            begin
                if (rem_reg >= dsh_ext)
                begin
                    rem_next = rem_reg - dsh_ext;
                    q_next   = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(Q_W - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_byte_next  = q_reg;
                    out_last_next  = res_last_reg;
                    for (int a = 0; a < 3; a++)
                    begin
                        out_min_next[a]   = res_min_reg[a];
                        out_range_next[a] = res_range_reg[a];
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            mc_reg        <= MC_W'(MC_RESET);
            mif_reg       <= '0;
            frames_reg    <= '0;
            fbase_reg     <= '0;
            dm_reg        <= '0;
            dax_reg       <= '0;
            df_reg        <= '0;
            daddr_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                lowest_reg[a]  <= COORD_MAX;
                highest_reg[a] <= COORD_MIN;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mc_reg        <= mc_next;
            mif_reg       <= mif_next;
            frames_reg    <= frames_next;
            fbase_reg     <= fbase_next;
            dm_reg        <= dm_next;
            dax_reg       <= dax_next;
            df_reg        <= df_next;
            daddr_reg     <= daddr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            for (int a = 0; a < 3; a++)
            begin
                lowest_reg[a]  <= lowest_next[a];
                highest_reg[a] <= highest_next[a];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        sel_ax_reg    <= sel_ax_next;
        sel_lo_reg    <= sel_lo_next;
        sel_range_reg <= sel_range_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        res_kind_reg  <= res_kind_next;
        res_last_reg  <= res_last_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        for (int a = 0; a < 3; a++)
        begin
            flo_reg[a]       <= flo_next[a];
            fhi_reg[a]       <= fhi_next[a];
            res_min_reg[a]   <= res_min_next[a];
            res_range_reg[a] <= res_range_next[a];
            out_min_reg[a]   <= out_min_next[a];
            out_range_reg[a] <= out_range_next[a];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign byte_value  = out_byte_reg;
    assign last_byte   = out_last_reg;
    assign min_x       = out_min_reg[0];
    assign min_y       = out_min_reg[1];
    assign min_z       = out_min_reg[2];
    assign range_x     = out_range_reg[0];
    assign range_y     = out_range_reg[1];
    assign range_z     = out_range_reg[2];

endmodule

// ===== rtl/core/psbq_checker.sv =====
// Port-level assertions for the point set byte quantizer, bound to the top level.
module psbq_checker
    import psbq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         kind,
    input logic               out_valid,
    input logic               out_ready,
    input logic               result_kind,
    input logic [Q_W-1:0]     byte_value,
    input logic               last_byte,
    input logic signed [COORD_W-1:0] min_x,
    input logic signed [COORD_W-1:0] min_y,
    input logic signed [COORD_W-1:0] min_z,
    input logic [COORD_W-1:0] range_x,
    input logic [COORD_W-1:0] range_y,
    input logic [COORD_W-1:0] range_z
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_kind) && $stable(byte_value)
                                    && $stable(last_byte))
        else $error("stalled result payload changed");

    // a report carries no byte, a byte carries no extents
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == RES_REPORT && byte_value == '0 && last_byte == 1'b0)
                      || (result_kind == RES_BYTE && min_x == '0 && min_y == '0
                          && min_z == '0 && range_x == '0 && range_y == '0
                          && range_z == '0))
        else $error("result fields inconsistent with result kind");

    // loads and unknown kinds never stall the input
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_LOAD || kind == KIND_UNUSED) |=> in_ready)
        else $error("input stalled after a load or unknown transaction");

endmodule

bind point_set_byte_quantizer psbq_checker u_psbq_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for point_set_byte_quantizer: directed table and random sessions.
module tb_top;
    import psbq_pkg::*;

    typedef enum logic {LOADING, DRAINING} quant_phase_t;
    typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_EDGES} spread_t;

    localparam int STEP_IGNORED = -1;
    localparam int STEP_SILENT  = 0;
    localparam int STEP_RESULT  = 1;

    typedef struct packed {
        logic                    rkind;
        logic [Q_W-1:0]          bval;
        logic                    lastb;
        logic [2:0][COORD_W-1:0] mins;
        logic [2:0][COORD_W-1:0] spans;
    } quant_result_t;

    typedef struct {
        kind_t         k;
        coord_t        x;
        coord_t        y;
        coord_t        z;
        bit            typed;
        quant_result_t res;
    } plan_row_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [MC_W-1:0] cfg_wdata;
    logic            in_valid;
    logic            in_ready;
    logic [1:0]      kind;
    coord_t          coord_x;
    coord_t          coord_y;
    coord_t          coord_z;
    logic            out_valid;
    logic            out_ready;
    logic            result_kind;
    logic [Q_W-1:0]  byte_value;
    logic            last_byte;
    coord_t          min_x;
    coord_t          min_y;
    coord_t          min_z;
    span_t           range_x;
    span_t           range_y;
    span_t           range_z;

    // predictor state
    coord_t       stored_pts [MAX_POINTS][3];
    coord_t       lowest [3];
    coord_t       highest [3];
    coord_t       frame_low [3];
    coord_t       frame_high [3];
    int unsigned  marker_idx;
    int unsigned  frames_done;
    int unsigned  drain_idx;
    int unsigned  markers_per_frame;
    quant_phase_t mode;

    quant_result_t expected_results [$];
    int            mismatches = 0;
    int            taken_items = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            hold_request = 0;
    string         axis_name [3] = '{"x", "y", "z"};

    point_set_byte_quantizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .byte_value  (byte_value),
        .last_byte   (last_byte),
        .min_x       (min_x),
        .min_y       (min_y),
        .min_z       (min_z),
        .range_x     (range_x),
        .range_y     (range_y),
        .range_z     (range_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("point_set_byte_quantizer: mismatch");
        $finish;
    end

    function automatic void start_session();
        for (int a = 0; a < 3; a++)
        begin
            lowest[a]     = COORD_MAX;
            highest[a]    = COORD_MIN;
            frame_low[a]  = '0;
            frame_high[a] = '0;
        end
        marker_idx  = 0;
        frames_done = 0;
        drain_idx   = 0;
        mode        = LOADING;
    endfunction

    function automatic void apply_marker_count(input logic [MC_W-1:0] v);
        int unsigned n;
        if (mode != LOADING || frames_done != 0 || marker_idx != 0)
            return;
        n = v;
        if (n == 0)
            n = 1;
        if (n > MC_MAX)
            n = MC_MAX;
        markers_per_frame = n;
    endfunction

    function automatic int predict_quantizer(input kind_t k, input coord_t cx, input coord_t cy,
                                             input coord_t cz, output quant_result_t r);
        coord_t      v [3];
        longint      off;
        longint      span;
        longint      q;
        int unsigned addr;
        int unsigned per_marker;
        int unsigned total;
        int unsigned m;
        int unsigned rem;
        int unsigned ax;
        int unsigned f;
        r = '0;
        v[0] = cx;
        v[1] = cy;
        v[2] = cz;
        if (k == KIND_LOAD && mode == LOADING)
        begin
            if ((frames_done + 1) * markers_per_frame > MAX_POINTS)
                return STEP_IGNORED;
            addr = frames_done * markers_per_frame + marker_idx;
            for (int a = 0; a < 3; a++)
            begin
                stored_pts[addr][a] = v[a];
                if (marker_idx == 0 || v[a] < frame_low[a])
                    frame_low[a] = v[a];
                if (marker_idx == 0 || v[a] > frame_high[a])
                    frame_high[a] = v[a];
            end
            marker_idx++;
            if (marker_idx >= markers_per_frame)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (frame_low[a] < lowest[a])
                        lowest[a] = frame_low[a];
                    if (frame_high[a] > highest[a])
                        highest[a] = frame_high[a];
                end
                marker_idx = 0;
                frames_done++;
            end
            return STEP_SILENT;
        end
        if (k == KIND_FINISH && mode == LOADING)
        begin
            r.rkind = RES_REPORT;
            if (frames_done == 0)
            begin
                start_session();
                return STEP_RESULT;
            end
            for (int a = 0; a < 3; a++)
            begin
                r.mins[a]  = lowest[a];
                r.spans[a] = highest[a] - lowest[a];
            end
            marker_idx = 0;
            drain_idx  = 0;
            mode       = DRAINING;
            return STEP_RESULT;
        end
        if (k == KIND_DRAIN && mode == DRAINING)
        begin
            per_marker = 3 * frames_done;
            total      = markers_per_frame * per_marker;
            m          = drain_idx / per_marker;
            rem        = drain_idx % per_marker;
            ax         = rem / frames_done;
            f          = rem % frames_done;
            addr       = f * markers_per_frame + m;
            span       = longint'(highest[ax]) - longint'(lowest[ax]);
            off        = longint'(stored_pts[addr][ax]) - longint'(lowest[ax]);
            q          = (span != 0) ? off * QUANT_SCALE / span : 0;
            r.rkind    = RES_BYTE;
            r.bval     = q[Q_W-1:0];
            r.lastb    = (drain_idx + 1 >= total);
            if (r.lastb)
                start_session();
            else
                drain_idx++;
            return STEP_RESULT;
        end
        return STEP_IGNORED;
    endfunction

    function automatic quant_result_t byte_res(input logic [Q_W-1:0] b, input logic last);
        quant_result_t r;
        r       = '0;
        r.rkind = RES_BYTE;
        r.bval  = b;
        r.lastb = last;
        return r;
    endfunction

    function automatic quant_result_t report_res(input coord_t mx, input coord_t my,
                                                 input coord_t mz, input span_t rx,
                                                 input span_t ry, input span_t rz);
        quant_result_t r;
        r          = '0;
        r.rkind    = RES_REPORT;
        r.mins[0]  = mx;
        r.mins[1]  = my;
        r.mins[2]  = mz;
        r.spans[0] = rx;
        r.spans[1] = ry;
        r.spans[2] = rz;
        return r;
    endfunction

    function automatic coord_t pick_coord(input spread_t s, input coord_t base);
        case (s)
            SPREAD_FULL:   return coord_t'($urandom());
            SPREAD_NARROW: return base + coord_t'($urandom_range(255));
            SPREAD_FLAT:   return base;
            default:
            begin
                case ($urandom_range(4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return coord_t'($urandom());
                endcase
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic offer_item(input kind_t k, input coord_t cx, input coord_t cy,
                              input coord_t cz, input bit typed, input quant_result_t typed_res);
        quant_result_t r;
        int            outcome;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        kind     <= k;
        coord_x  <= cx;
        coord_y  <= cy;
        coord_z  <= cz;
        do @(posedge clk); while (!in_ready);
        outcome = predict_quantizer(k, cx, cy, cz, r);
        if (outcome != STEP_IGNORED)
            taken_items++;
        if (typed)
            expected_results.insert(expected_results.size(), typed_res);
        else if (outcome == STEP_RESULT)
            expected_results.insert(expected_results.size(), r);
    endtask

    task automatic send_item(input kind_t k, input coord_t cx, input coord_t cy, input coord_t cz);
        offer_item(k, cx, cy, cz, 1'b0, '0);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic write_marker_count(input logic [MC_W-1:0] v);
        wait_for_results();
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        apply_marker_count(v);
    endtask

    task automatic random_session(input bit hold_drains, input bit pause_mid, input bit fill_store);
        spread_t     spread [3];
        coord_t      base [3];
        coord_t      c [3];
        int unsigned frames;
        int unsigned extra;
        int unsigned drains;
        int unsigned noise;
        for (int a = 0; a < 3; a++)
        begin
            spread[a] = spread_t'($urandom_range(3));
            base[a]   = coord_t'($urandom());
        end
        if (fill_store)
        begin
            frames = MAX_POINTS / markers_per_frame;
            extra  = markers_per_frame;
        end
        else
        begin
            frames = (markers_per_frame > 8) ? 1 : $urandom_range(1, 4);
            if ($urandom_range(11) == 0)
                frames = 0;
            extra = 0;
            if (markers_per_frame > 1 && $urandom_range(3) == 0)
                extra = $urandom_range(1, markers_per_frame - 1);
        end
        for (int i = 0; i < frames * markers_per_frame + extra; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item($urandom_range(1) ? KIND_DRAIN : KIND_UNUSED, coord_t'($urandom()),
                          coord_t'($urandom()), coord_t'($urandom()));
            for (int a = 0; a < 3; a++)
                c[a] = pick_coord(spread[a], base[a]);
            send_item(KIND_LOAD, c[0], c[1], c[2]);
        end
        send_item(KIND_FINISH, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
        if (frames == 0)
            return;
        if (hold_drains)
            hold_request = 200;
        drains = 3 * frames * markers_per_frame;
        for (int i = 0; i < drains; i++)
        begin
            if (pause_mid && i == drains / 2)
                wait_for_results();
            if ($urandom_range(19) == 0)
            begin
                noise = $urandom_range(2);
                send_item(noise == 0 ? KIND_LOAD : (noise == 1 ? KIND_FINISH : KIND_UNUSED),
                          coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
            end
            send_item(KIND_DRAIN, coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()));
        end
        if ($urandom_range(3) == 0)
            send_item(KIND_DRAIN, coord_t'($urandom()), coord_t'($urandom()),
                      coord_t'($urandom()));
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        quant_result_t got;
        quant_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.rkind    = result_kind;
            got.bval     = byte_value;
            got.lastb    = last_byte;
            got.mins[0]  = min_x;
            got.mins[1]  = min_y;
            got.mins[2]  = min_z;
            got.spans[0] = range_x;
            got.spans[1] = range_y;
            got.spans[2] = range_z;
            if (expected_results.size() == 0)
                note_mismatch("result with nothing pending, result_kind", got.rkind, 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.rkind !== want.rkind)
                    note_mismatch("result_kind", got.rkind, want.rkind);
                if (got.bval !== want.bval)
                    note_mismatch("byte_value", got.bval, want.bval);
                if (got.lastb !== want.lastb)
                    note_mismatch("last_byte", got.lastb, want.lastb);
                for (int a = 0; a < 3; a++)
                begin
                    if (got.mins[a] !== want.mins[a])
                        note_mismatch({"min_", axis_name[a]}, got.mins[a], want.mins[a]);
                    if (got.spans[a] !== want.spans[a])
                        note_mismatch({"range_", axis_name[a]}, got.spans[a], want.spans[a]);
                end
            end
        end
    end

    initial
    begin
        plan_row_t        plan [17];
        logic [MC_W-1:0]  count;
        int               phase_start;
        bit               first;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        kind      <= KIND_LOAD;
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        markers_per_frame = MC_RESET;
        start_session();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_marker_count(7'd2);
        plan = '{
            '{KIND_DRAIN,  24'sd3,   24'sd4,   24'sd5,   1'b0, '0},
            '{KIND_UNUSED, 24'sd1,   24'sd2,   24'sd3,   1'b0, '0},
            '{KIND_FINISH, '0,       '0,       '0,       1'b1,
              report_res('0, '0, '0, '0, '0, '0)},
            '{KIND_LOAD,   COORD_MAX, COORD_MIN, '0,     1'b0, '0},
            '{KIND_LOAD,   COORD_MIN, COORD_MAX, '0,     1'b0, '0},
            '{KIND_LOAD,   '0,       '0,       24'sd100, 1'b0, '0},
            '{KIND_FINISH, '0,       '0,       '0,       1'b1,
              report_res(COORD_MIN, COORD_MIN, '0, '1, '1, '0)},
            '{KIND_LOAD,   24'sd7,   24'sd7,   24'sd7,   1'b0, '0},
            '{KIND_FINISH, '0,       '0,       '0,       1'b0, '0},
            '{KIND_UNUSED, '0,       '0,       '0,       1'b0, '0},
            '{KIND_DRAIN,  '0,       '0,       '0,       1'b1, byte_res(8'd255, 1'b0)},
            '{KIND_DRAIN,  '0,       '0,       '0,       1'b1, byte_res(8'd0, 1'b0)},
            '{KIND_DRAIN,  '0,       '0,       '0,       1'b1, byte_res(8'd0, 1'b0)},
            '{KIND_DRAIN,  '0,       '0,       '0,       1'b1, byte_res(8'd0, 1'b0)},
            '{KIND_DRAIN,  '0,       '0,       '0,       1'b1, byte_res(8'd255, 1'b0)},
            '{KIND_DRAIN,  '0,       '0,       '0,       1'b1, byte_res(8'd0, 1'b1)},
            '{KIND_DRAIN,  '1,       '1,       '1,       1'b0, '0}
        };
        foreach (plan[i])
            offer_item(plan[i].k, plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].res);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    count     = 7'd0;
                end
                1:
                begin
                    idle_pct  = 71;
                    stall_pct = 0;
                    count     = 7'd127;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 71;
                    count     = MC_W'(MC_RESET);
                end
                default:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                    count     = 7'd3;
                end
            endcase
            write_marker_count(count);
            phase_start = taken_items;
            first       = 1'b1;
            while (taken_items - phase_start < 125)
            begin
                if (!first && $urandom_range(2) == 0)
                begin
                    case ($urandom_range(19))
                        0:       count = 7'd0;
                        1:       count = 7'd127;
                        2:       count = MC_W'(MC_MAX);
                        3:       count = MC_W'(MC_RESET);
                        default: count = MC_W'($urandom_range(1, 6));
                    endcase
                    write_marker_count(count);
                end
                random_session(ph == 0 && first, ph == 1 && first, 1'b0);
                first = 1'b0;
            end
        end

        in_valid <= 1'b0;
        for (int n = 0; n < 20000 && expected_results.size() != 0; n++)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results never delivered", expected_results.size(), 0);
        if (mismatches == 0)
            $display("point_set_byte_quantizer: match");
        else
            $display("point_set_byte_quantizer: mismatch");
        $finish;
    end

endmodule
